>>> src/gbn_pkg.sv
// ----------------------------------------------------------------------------
// Go-back-N sender package
// Shared widths, command and register codes, and the request and result
// structures that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // Field widths fixed by the interface.
  localparam int SEQ_W     = 16;
  localparam int WIN_W     = 9;
  localparam int CNT_W     = 32;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Packed bus widths, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;

  // Depth of the queue between the front end and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Register reset values.
  localparam logic [WIN_W-1:0] WINDOW_RESET  = 9'd4;
  localparam logic [SEQ_W-1:0] FRAMES_RESET  = 16'd0;
  localparam logic [SEQ_W-1:0] TIMEOUT_RESET = 16'd1500;

  // Request kinds carried on the input channel.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_SEND = 2'd2
  } gbn_cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE   = 2'd0,
    REG_TOTAL_FRAMES  = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } gbn_reg_t;

  // A classified request as it waits in the queue.
  typedef struct packed {
    logic             tick;
    logic             ack;
    logic             send;
    logic             abort;
    logic [SEQ_W-1:0] ack_seq;
  } gbn_item_t;

  // One result, fields listed from the highest bit down.
  typedef struct packed {
    logic [CNT_W-1:0] retransmit_total;
    logic [WIN_W-1:0] in_flight;
    logic             done_res;
    logic [SEQ_W-1:0] send_seq;
    logic             send_valid;
  } gbn_result_t;

  // A configuration write as seen by the back end.
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] wdata;
  } gbn_cfg_wr_t;

endpackage

>>> src/go_back_n_sender.sv
// Path: a request accepted on the input channel passes the front register, a queue slot
// and the output register, in that order, before it reaches the output channel.
// Throughput: one request per cycle while the output is not stalled, set by the state
// update in the back end; the queue lets either channel stall without losing a slot.
// Reset: synchronous active-low; window state, counters and handshakes clear,
// and the configuration registers return to their reset values.
// ----------------------------------------------------------------------------
// Go-back-N sender
// Takes time ticks, acknowledgements and send slots, hands out frame numbers
// within the window, and rewinds to the oldest unacknowledged frame on timeout.
// ----------------------------------------------------------------------------
module go_back_n_sender #(
  parameter int MAX_WINDOW = 256,
  parameter int SEQ_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gbn_pkg::IN_DATA_W-1:0]     in_tdata,   // ack_seq[15:0], ack_abort
  input  logic [gbn_pkg::CMD_W-1:0]         in_tuser,   // cmd
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gbn_pkg::OUT_DATA_W-1:0]    out_tdata,  // send_valid, send_seq[15:0],
                                                        // done_res, in_flight[8:0],
                                                        // retransmit_total[31:0]
  // Configuration port
  input  logic                              cfg_we,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gbn_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  localparam int ITEM_W = $bits(gbn_pkg::gbn_item_t);
  localparam int RES_W  = $bits(gbn_pkg::gbn_result_t);

  logic                 fq_valid;
  logic                 fq_ready;
  gbn_pkg::gbn_item_t   fq_item;
  logic                 qb_valid;
  logic                 qb_ready;
  logic [ITEM_W-1:0]    qb_data;
  gbn_pkg::gbn_cfg_wr_t cfg_wr;
  gbn_pkg::gbn_result_t res;

  assign cfg_wr = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};

  // Front end: accept and classify requests.
  gbn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  // Queue between the two halves.
  gbn_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (gbn_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_item),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // Back end: window state and results.
  gbn_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SEQ_BITS   (SEQ_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .q_valid   (qb_valid),
    .q_ready   (qb_ready),
    .q_item    (gbn_pkg::gbn_item_t'(qb_data)),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result, send_valid in the lowest bit, zero padded.
  assign out_tdata = {{(gbn_pkg::OUT_DATA_W-RES_W){1'b0}}, res};

endmodule

>>> src/gbn_front.sv
// ----------------------------------------------------------------------------
// Go-back-N sender front end
// Accepts requests from the input channel, decodes the command into flags and
// hands the classified request on to the queue.
// ----------------------------------------------------------------------------
module gbn_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [gbn_pkg::IN_DATA_W-1:0]        in_tdata,  // ack_seq, ack_abort
  input  logic [gbn_pkg::CMD_W-1:0]            in_tuser,  // cmd
  output logic                                 q_valid,
  input  logic                                 q_ready,
  output gbn_pkg::gbn_item_t                   q_item
);

  logic               hold_valid_r;
  logic               hold_valid_nxt;
  gbn_pkg::gbn_item_t hold_item_r;
  gbn_pkg::gbn_item_t item_nxt;
  logic               in_acc;
  logic               push;

  // The holding register frees up whenever the queue takes its request.
  assign push      = hold_valid_r && q_ready;
  assign in_tready = !hold_valid_r || q_ready;
  assign in_acc    = in_tvalid && in_tready;

  // Decode the command; the unused code leaves the tick, ack and send flags clear.
  always_comb begin
    item_nxt         = '0;
    item_nxt.ack_seq = in_tdata[gbn_pkg::SEQ_W-1:0];
    item_nxt.abort   = in_tdata[gbn_pkg::SEQ_W];
    case (gbn_pkg::gbn_cmd_t'(in_tuser))
      gbn_pkg::CMD_TICK: item_nxt.tick = 1'b1;
      gbn_pkg::CMD_ACK:  item_nxt.ack  = 1'b1;
      gbn_pkg::CMD_SEND: item_nxt.send = 1'b1;
      default:           item_nxt.tick = 1'b0;
    endcase
  end

  // Occupancy of the holding register.
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_acc) begin
      hold_valid_nxt = 1'b1;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_item_r <= item_nxt;
    end
  end

  assign q_valid = hold_valid_r;
  assign q_item  = hold_item_r;

endmodule

>>> src/gbn_queue.sv
// ----------------------------------------------------------------------------
// Go-back-N sender request queue
// A short first-in first-out queue that lets the front end and the back end
// stall independently of each other.
// ----------------------------------------------------------------------------
module gbn_queue #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count_r != FULL_CNT);
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = slot_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> src/gbn_back.sv
// ----------------------------------------------------------------------------
// Go-back-N sender back end
// Holds the configuration and the window state and carries out one request
// per cycle unless stalled; an output register keeps each result until taken.
// ----------------------------------------------------------------------------
module gbn_back #(
  parameter int MAX_WINDOW = 256,
  parameter int SEQ_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gbn_pkg::gbn_cfg_wr_t cfg_wr,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  gbn_pkg::gbn_item_t   q_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output gbn_pkg::gbn_result_t res
);

  localparam int SW = gbn_pkg::SEQ_W;
  localparam int CW = gbn_pkg::CNT_W;
  localparam int WW = gbn_pkg::WIN_W;
  localparam int MASK_BITS = (SEQ_BITS < SW) ? SEQ_BITS : SW;
  localparam logic [31:0]   ONE32    = 32'd1;
  localparam logic [SW-1:0] SEQ_MASK = SW'((ONE32 << MASK_BITS) - ONE32);
  localparam logic [SW-1:0] MAX_WIN  = SW'(MAX_WINDOW);

  // Configuration registers.
  logic [WW-1:0] window_size_r;
  logic [SW-1:0] total_frames_r;
  logic [SW-1:0] timeout_ticks_r;

  // Window state.
  logic [SW-1:0] next_seq_r,     next_seq_nxt;
  logic [SW-1:0] window_base_r,  window_base_nxt;
  logic [SW-1:0] idle_timer_r,   idle_timer_nxt;
  logic [CW-1:0] resent_count_r, resent_count_nxt;
  logic          finished_r,     finished_nxt;

  // Output register.
  logic                 res_valid_r;
  logic                 res_valid_nxt;
  gbn_pkg::gbn_result_t res_r;
  gbn_pkg::gbn_result_t res_nxt;

  logic          pop;
  logic [SW-1:0] flight;
  logic [SW-1:0] eff_window;
  logic [SW-1:0] timer_inc;
  logic [SW-1:0] base_inc;
  logic [CW:0]   resent_sum;
  logic          active;
  logic          send_ok;

  // A request is carried out whenever the output register is free or emptying.
  assign pop     = q_valid && (!res_valid_r || res_ready);
  assign q_ready = !res_valid_r || res_ready;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r   <= gbn_pkg::WINDOW_RESET;
      total_frames_r  <= gbn_pkg::FRAMES_RESET;
      timeout_ticks_r <= gbn_pkg::TIMEOUT_RESET;
    end else if (cfg_wr.we) begin
      case (gbn_pkg::gbn_reg_t'(cfg_wr.index))
        gbn_pkg::REG_WINDOW_SIZE:   window_size_r   <= cfg_wr.wdata[WW-1:0];
        gbn_pkg::REG_TOTAL_FRAMES:  total_frames_r  <= cfg_wr.wdata[SW-1:0];
        gbn_pkg::REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wr.wdata[SW-1:0];
        default:                    ;
      endcase
    end
  end

  // Effective window: zero acts as one, and it never exceeds the maximum.
  always_comb begin
    if (window_size_r == '0) begin
      eff_window = SW'(1);
    end else if ({{(SW-WW){1'b0}}, window_size_r} > MAX_WIN) begin
      eff_window = MAX_WIN;
    end else begin
      eff_window = {{(SW-WW){1'b0}}, window_size_r};
    end
  end

  assign flight     = next_seq_r - window_base_r;
  assign timer_inc  = (idle_timer_r != '1) ? idle_timer_r + SW'(1) : idle_timer_r;
  assign base_inc   = window_base_r + SW'(1);
  assign resent_sum = {1'b0, resent_count_r} + {{(CW+1-SW){1'b0}}, flight};
  assign active     = !finished_r && (window_base_r < total_frames_r);
  assign send_ok    = (flight < eff_window) && (next_seq_r < total_frames_r);

  // Carry out one request against the window state.
  always_comb begin
    next_seq_nxt     = next_seq_r;
    window_base_nxt  = window_base_r;
    idle_timer_nxt   = idle_timer_r;
    resent_count_nxt = resent_count_r;
    finished_nxt     = finished_r;
    res_nxt          = '0;

    if (active) begin
      if (q_item.tick) begin
        if (flight != '0) begin
          if (timer_inc >= timeout_ticks_r) begin
            // Timeout: rewind to the oldest frame and count the resends.
            resent_count_nxt = resent_sum[CW] ? '1 : resent_sum[CW-1:0];
            next_seq_nxt     = window_base_r;
            idle_timer_nxt   = '0;
          end else begin
            idle_timer_nxt = timer_inc;
          end
        end else begin
          idle_timer_nxt = '0;
        end
      end else if (q_item.ack) begin
        if (q_item.abort) begin
          finished_nxt = 1'b1;
        end else if ((flight != '0) &&
                     ((q_item.ack_seq & SEQ_MASK) == (window_base_r & SEQ_MASK))) begin
          window_base_nxt = base_inc;
          idle_timer_nxt  = '0;
          if (base_inc >= total_frames_r) begin
            finished_nxt = 1'b1;
          end
        end
      end else if (q_item.send) begin
        if (send_ok) begin
          res_nxt.send_valid = 1'b1;
          res_nxt.send_seq   = next_seq_r & SEQ_MASK;
          next_seq_nxt       = next_seq_r + SW'(1);
        end
      end
    end

    res_nxt.done_res         = finished_nxt || (window_base_nxt >= total_frames_r);
    res_nxt.in_flight        = WW'(next_seq_nxt - window_base_nxt);
    res_nxt.retransmit_total = resent_count_nxt;
  end

  // Output register occupancy.
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (pop) begin
      res_valid_nxt = 1'b1;
    end else if (res_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r     <= '0;
      window_base_r  <= '0;
      idle_timer_r   <= '0;
      resent_count_r <= '0;
      finished_r     <= 1'b0;
      res_valid_r    <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (pop) begin
        next_seq_r     <= next_seq_nxt;
        window_base_r  <= window_base_nxt;
        idle_timer_r   <= idle_timer_nxt;
        resent_count_r <= resent_count_nxt;
        finished_r     <= finished_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

`ifndef SYNTHESIS
  // Once the transfer has ended it stays ended.
  a_finished_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag cleared after the transfer ended");

  // The idle timer rests at zero whenever nothing is outstanding.
  a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (next_seq_r == window_base_r) |-> (idle_timer_r == '0))
    else $error("idle timer running with nothing outstanding");

  // The retransmit total never goes down.
  a_resent_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (resent_count_r >= $past(resent_count_r)))
    else $error("retransmit total decreased");

  // A held result is never overwritten by a new request.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_ready) |-> !pop)
    else $error("request carried out while the result was stalled");
`endif

endmodule
